@@ rtl/a64_data_proc_immediate_exec_top_macros.svh @@
// Assertion macros shared by the checker of the immediate executor.
// No dependencies; include by bare file name.
`ifndef A64_DATA_PROC_IMMEDIATE_EXEC_TOP_MACROS_SVH
`define A64_DATA_PROC_IMMEDIATE_EXEC_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define A64DPI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define A64DPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always checked (for reset behavior)
`define A64DPI_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/a64dpi_pkg.sv @@
// Shared types and encodings of the A64 data-processing-immediate executor.
// No dependencies.
package a64dpi_pkg;

  localparam int NUM_REGS  = 32;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int XLEN      = 64;

  localparam logic [2:0] OPI_ARITH = 3'd2;
  localparam logic [2:0] OPI_WIDE  = 3'd5;

  localparam logic [1:0] OPC_MOVN = 2'd0;
  localparam logic [1:0] OPC_BAD  = 2'd1;
  localparam logic [1:0] OPC_MOVZ = 2'd2;
  localparam logic [1:0] OPC_MOVK = 2'd3;

  localparam logic [XLEN-1:0] MASK_W32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [XLEN-1:0] MASK_HW  = 64'h0000_0000_0000_FFFF;

  // one executed instruction: write-back plus flags after it
  typedef struct packed {
    logic [REG_IDX_W-1:0] dest;
    logic [XLEN-1:0]      value;
    logic                 we;
    logic                 fu;
    logic [3:0]           nzcv;   // N=3 Z=2 C=1 V=0
  } result_t;

endpackage

@@ rtl/a64_data_proc_immediate_exec_top.sv @@
// A64 data-processing-immediate executor (add/sub immediate, move wide): top level.
// Uses a64dpi_pkg, a64dpi_alu and a64dpi_regs.
//
// Takes one instruction word per beat and returns one result beat per word: the
// register written, the width-masked value, and the NZCV flags after the
// instruction. Sustained rate is one instruction per cycle while out_ready is
// high. A word waits in the input register, then its result is registered in the
// result register, where out_valid rises and the beat can be taken. The
// register file and flags are written at the same edge the result is registered,
// so a dependent instruction can follow in the very next cycle. When out_ready is
// low, one more instruction is taken into the input register before in_ready drops.
module a64_data_proc_immediate_exec_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  dest_index,
  output logic [63:0] write_value,
  output logic        write_enable,
  output logic        flags_updated,
  output logic        flag_negative,
  output logic        flag_zero,
  output logic        flag_carry,
  output logic        flag_overflow
);
  import a64dpi_pkg::*;

  logic                 inst_valid;
  logic [31:0]          inst;
  logic                 exec_fire;
  logic [REG_IDX_W-1:0] src_addr;
  logic [XLEN-1:0]      src_data;
  logic [3:0]           flags;
  result_t              res_next;
  result_t              res;

  assign exec_fire = inst_valid && (!out_valid || out_ready);
  assign in_ready  = !inst_valid || exec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inst_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        inst_valid <= in_valid;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inst <= instr_word;
    end
    if (exec_fire) begin
      res <= res_next;
    end
  end

  a64dpi_alu u_alu (
    .instr    (inst),
    .src_addr (src_addr),
    .src_data (src_data),
    .flags    (flags),
    .res      (res_next)
  );

  a64dpi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (src_addr),
    .rd_data (src_data),
    .flags   (flags),
    .wr_fire (exec_fire),
    .wr      (res_next)
  );

  assign dest_index    = res.dest;
  assign write_value   = res.value;
  assign write_enable  = res.we;
  assign flags_updated = res.fu;
  assign flag_negative = res.nzcv[3];
  assign flag_zero     = res.nzcv[2];
  assign flag_carry    = res.nzcv[1];
  assign flag_overflow = res.nzcv[0];

endmodule

@@ rtl/a64dpi_regs.sv @@
// Architectural state: 32 x 64-bit register file and NZCV flags.
// Depends on a64dpi_pkg.
module a64dpi_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [a64dpi_pkg::REG_IDX_W-1:0] rd_addr,
  output logic [a64dpi_pkg::XLEN-1:0]  rd_data,
  output logic [3:0]                   flags,
  input  logic                         wr_fire,
  input  a64dpi_pkg::result_t          wr
);
  import a64dpi_pkg::*;

  logic [XLEN-1:0] reg_file [NUM_REGS];

  assign rd_data = reg_file[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_file[i] <= '0;
      end
      flags <= '0;
    end else if (wr_fire) begin
      if (wr.we) begin
        reg_file[wr.dest] <= wr.value;
      end
      if (wr.fu) begin
        flags <= wr.nzcv;
      end
    end
  end

endmodule

@@ rtl/a64dpi_alu.sv @@
// Decode and execute of add/sub immediate and move wide, combinational.
// Depends on a64dpi_pkg.
module a64dpi_alu (
  input  logic [31:0]                      instr,
  output logic [a64dpi_pkg::REG_IDX_W-1:0] src_addr,
  input  logic [a64dpi_pkg::XLEN-1:0]      src_data,
  input  logic [3:0]                       flags,
  output a64dpi_pkg::result_t              res
);
  import a64dpi_pkg::*;

  logic            sf;
  logic [1:0]      opc;
  logic [2:0]      opi;
  logic [XLEN-1:0] wmask;
  logic [XLEN-1:0] a;
  logic [XLEN-1:0] imm;
  logic [XLEN-1:0] b;
  logic            sub;
  logic [XLEN:0]   sum;
  logic [XLEN-1:0] arith_val;
  logic            sa, sb, sr, c_out;
  logic [5:0]      pos;
  logic [XLEN-1:0] placed;
  logic [XLEN-1:0] keep;
  logic [XLEN-1:0] wide_val;

  assign sf  = instr[31];
  assign opc = instr[30:29];
  assign opi = instr[25:23];

  assign wmask = sf ? '1 : MASK_W32;

  // movk reads rd, add/sub reads rn
  assign src_addr = (opi == OPI_ARITH) ? instr[9:5] : instr[4:0];
  assign a        = src_data & wmask;

  // add/sub: subtract as a + ~imm + 1 within the width
  assign imm = instr[22] ? {40'd0, instr[21:10], 12'd0} : {52'd0, instr[21:10]};
  assign sub = opc[1];
  assign b   = sub ? (~imm & wmask) : imm;
  assign sum = {1'b0, a} + {1'b0, b} + {{XLEN{1'b0}}, sub};
  assign arith_val = sum[XLEN-1:0] & wmask;

  assign c_out = sf ? sum[XLEN] : sum[32];
  assign sa    = sf ? a[XLEN-1] : a[31];
  assign sb    = sf ? b[XLEN-1] : b[31];
  assign sr    = sf ? arith_val[XLEN-1] : arith_val[31];

  // move wide
  assign pos    = {instr[22:21], 4'b0000};
  assign placed = {48'd0, instr[20:5]} << pos;
  assign keep   = ~(MASK_HW << pos);

  always_comb begin
    case (opc)
      OPC_MOVN: wide_val = ~placed & wmask;
      OPC_MOVZ: wide_val = placed & wmask;
      OPC_MOVK: wide_val = ((a & keep) | placed) & wmask;
      default:  wide_val = '0;
    endcase
  end

  always_comb begin
    res.dest  = instr[4:0];
    res.value = '0;
    res.we    = 1'b0;
    res.fu    = 1'b0;
    res.nzcv  = flags;
    case (opi)
      OPI_ARITH: begin
        res.value = arith_val;
        res.we    = 1'b1;
        if (opc[0]) begin
          res.fu   = 1'b1;
          res.nzcv = {sr, (arith_val == '0), c_out, ((sa == sb) && (sr != sa))};
        end
      end
      OPI_WIDE: begin
        if (opc != OPC_BAD) begin
          res.value = wide_val;
          res.we    = 1'b1;
        end
      end
      default: begin
        res.we = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/a64dpi_checker.sv @@
// Port-level checks of the immediate executor, bound to the top level.
// Depends on a64_data_proc_immediate_exec_top_macros.svh.
`include "a64_data_proc_immediate_exec_top_macros.svh"

module a64dpi_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  dest_index,
  input logic [63:0] write_value,
  input logic        write_enable,
  input logic        flags_updated,
  input logic        flag_zero
);

  // a stalled result beat holds
`A64DPI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(write_value) && $stable(dest_index), "result beat changed while stalled")

  // nothing pending out of reset
`A64DPI_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid, "out_valid after reset")

  // flag-setting forms always write a register; no write means zero value
`A64DPI_ASSERT_IMPLY(a_no_write, clk, rst, out_valid && (flags_updated || !write_enable), write_enable || (write_value == 64'd0), "value or flags without a write")

  // Z follows the result of adds/subs
`A64DPI_ASSERT_IMPLY(a_zero_flag, clk, rst, out_valid && flags_updated, flag_zero == (write_value == 64'd0), "Z does not match result")

endmodule

bind a64_data_proc_immediate_exec_top a64dpi_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .dest_index    (dest_index),
  .write_value   (write_value),
  .write_enable  (write_enable),
  .flags_updated (flags_updated),
  .flag_zero     (flag_zero)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the A64 immediate executor (add/sub imm, move wide).
// Depends on a64dpi_pkg and a64_data_proc_immediate_exec_top; runs a directed table,
// then random instruction words, with a shadow register file and flags for prediction.
module tb_top;
  import a64dpi_pkg::*;

  // add/sub group: opc[1] selects subtract, opc[0] selects flag update
  localparam logic [1:0] OPC_ADD  = 2'd0;
  localparam logic [1:0] OPC_ADDS = 2'd1;
  localparam logic [1:0] OPC_SUB  = 2'd2;
  localparam logic [1:0] OPC_SUBS = 2'd3;

  // other op0 groups of the immediate class, not executed here
  localparam logic [2:0] OPI_PCREL   = 3'd0;
  localparam logic [2:0] OPI_LOGICAL = 3'd4;
  localparam logic [2:0] OPI_EXTRACT = 3'd7;

  localparam logic [2:0] FAM_DPI  = 3'b100;  // bits [28:26] of the immediate class
  localparam int N_RANDOM      = 1150;
  localparam int WATCHDOG      = 2000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 60;
  localparam int HOLD_AFTER    = 300;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] instr_word;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  dest_index;
  logic [63:0] write_value;
  logic        write_enable;
  logic        flags_updated;
  logic        flag_negative;
  logic        flag_zero;
  logic        flag_carry;
  logic        flag_overflow;

  logic [63:0] shadow_regs [NUM_REGS];
  logic [3:0]  shadow_nzcv;
  result_t     pending_writes [$];
  stim_row_t   dir_rows [$];
  int          errors;
  int          beats_out;
  int          idle_cycles;
  bit          snd_burst;
  bit          rcv_burst;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  a64_data_proc_immediate_exec_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .instr_word   (instr_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dest_index   (dest_index),
    .write_value  (write_value),
    .write_enable (write_enable),
    .flags_updated(flags_updated),
    .flag_negative(flag_negative),
    .flag_zero    (flag_zero),
    .flag_carry   (flag_carry),
    .flag_overflow(flag_overflow)
  );

  function automatic logic [31:0] enc_arith(input logic sf, input logic [1:0] opc,
                                            input logic sh, input logic [11:0] imm12,
                                            input logic [4:0] rn, input logic [4:0] rd,
                                            input logic [2:0] fam);
    return {sf, opc, fam, OPI_ARITH, sh, imm12, rn, rd};
  endfunction

  function automatic logic [31:0] enc_wide(input logic sf, input logic [1:0] opc,
                                           input logic [1:0] hw, input logic [15:0] imm16,
                                           input logic [4:0] rd, input logic [2:0] fam);
    return {sf, opc, fam, OPI_WIDE, hw, imm16, rd};
  endfunction

  function automatic result_t mk_res(input logic [4:0] dest, input logic [63:0] value,
                                     input logic we, input logic fu, input logic [3:0] nzcv);
    result_t r;
    r.dest  = dest;
    r.value = value;
    r.we    = we;
    r.fu    = fu;
    r.nzcv  = nzcv;
    return r;
  endfunction

  // executes one word on the shadow state and returns the write-back it causes
  function automatic result_t exec_instr(input logic [31:0] w);
    result_t     r;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [1:0]  opc;
    logic [1:0]  hw;
    logic        sf;
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] imm;
    logic [63:0] placed;
    logic [63:0] lane;
    logic [64:0] sum;
    int          top;
    rd   = w[4:0];
    rn   = w[9:5];
    opc  = w[30:29];
    sf   = w[31];
    hw   = w[22:21];
    mask = sf ? '1 : MASK_W32;
    top  = sf ? 63 : 31;
    r    = mk_res(rd, '0, 1'b0, 1'b0, 4'b0000);
    if (w[25:23] == OPI_ARITH) begin
      imm = {52'd0, w[21:10]};
      if (w[22]) imm = imm << 12;
      a   = shadow_regs[rn] & mask;
      b   = opc[1] ? (~imm & mask) : imm;
      sum = {1'b0, a} + {1'b0, b} + {64'd0, opc[1]};
      r.value = sum[63:0] & mask;
      r.we    = 1'b1;
      if (opc[0]) begin
        shadow_nzcv[3] = r.value[top];
        shadow_nzcv[2] = (r.value == '0);
        shadow_nzcv[1] = sf ? sum[64] : sum[32];
        shadow_nzcv[0] = (a[top] == b[top]) && (r.value[top] != a[top]);
        r.fu = 1'b1;
      end
    end else if (w[25:23] == OPI_WIDE && opc != OPC_BAD) begin
      placed = {48'd0, w[20:5]} << {hw, 4'b0000};
      lane   = MASK_HW << {hw, 4'b0000};
      case (opc)
        OPC_MOVN: r.value = ~placed & mask;
        OPC_MOVZ: r.value = placed & mask;
        default:  r.value = ((shadow_regs[rd] & ~lane) | placed) & mask;
      endcase
      r.we = 1'b1;
    end
    if (r.we) shadow_regs[rd] = r.value;
    r.nzcv = shadow_nzcv;
    return r;
  endfunction

  // small register set most of the time so results feed later operands
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] rand_word();
    int          sel;
    logic [2:0]  fam;
    logic [11:0] imm12;
    logic [15:0] imm16;
    sel = $urandom_range(0, 99);
    fam = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : FAM_DPI;
    case ($urandom_range(0, 3))
      0:       begin imm12 = 12'h000; imm16 = 16'h0000; end
      1:       begin imm12 = 12'hFFF; imm16 = 16'hFFFF; end
      2:       begin imm12 = 12'h001; imm16 = 16'h8000; end
      default: begin imm12 = 12'($urandom); imm16 = 16'($urandom); end
    endcase
    if (sel < 45)
      return enc_arith(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), imm12, pick_reg(), pick_reg(), fam);
    else if (sel < 88)
      return enc_wide(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                      2'($urandom_range(0, 3)), imm16, pick_reg(), fam);
    return $urandom;
  endfunction

  function automatic int snd_gap();
    if ($urandom_range(0, 49) == 0) snd_burst = !snd_burst;
    return snd_burst ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic add_row(input logic [31:0] w, input bit typed, input result_t want);
    stim_row_t row;
    row.word  = w;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic drive_beat(input logic [31:0] w, input bit typed, input result_t want,
                            input int gap);
    result_t pred;
    if (gap > 0) begin
      in_valid   <= 1'b0;
      instr_word <= $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    instr_word <= w;
    do @(posedge clk); while (!in_ready);
    pred = exec_instr(w);
    pending_writes.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual dest %0d value %h",
                 $time, dest_index, write_value);
        errors++;
      end else begin
        e = pending_writes.pop_front();
        check_field("dest_index", 64'(e.dest), 64'(dest_index));
        check_field("write_value", e.value, write_value);
        check_field("write_enable", 64'(e.we), 64'(write_enable));
        check_field("flags_updated", 64'(e.fu), 64'(flags_updated));
        check_field("flag_negative", 64'(e.nzcv[3]), 64'(flag_negative));
        check_field("flag_zero", 64'(e.nzcv[2]), 64'(flag_zero));
        check_field("flag_carry", 64'(e.nzcv[1]), 64'(flag_carry));
        check_field("flag_overflow", 64'(e.nzcv[0]), 64'(flag_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold so the pipe backs up
  initial begin
    int  stall;
    bit  held;
    held      = 1'b0;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rcv_burst = !rcv_burst;
      stall = rcv_burst ? 0 : $urandom_range(0, 8);
      if (!held && beats_out >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    instr_word  = '0;
    errors      = 0;
    beats_out   = 0;
    idle_cycles = 0;
    snd_burst   = 1'b0;
    rcv_burst   = 1'b0;
    shadow_nzcv = '0;
    for (int i = 0; i < NUM_REGS; i++) shadow_regs[i] = '0;

    // move wide: extremes, 32-bit with hw above bit 31, movk keeps other lanes
    add_row(enc_wide(1'b1, OPC_MOVZ, 2'd3, 16'hFFFF, 5'd0, FAM_DPI), 1'b1,
            mk_res(5'd0, 64'hFFFF_0000_0000_0000, 1'b1, 1'b0, 4'b0000));
    add_row(enc_wide(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd1, FAM_DPI), 1'b1,
            mk_res(5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'b0000));
    add_row(enc_wide(1'b0, OPC_MOVN, 2'd0, 16'h0000, 5'd2, FAM_DPI), 1'b1,
            mk_res(5'd2, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 4'b0000));
    add_row(enc_wide(1'b1, OPC_MOVK, 2'd0, 16'h1234, 5'd0, FAM_DPI), 1'b1,
            mk_res(5'd0, 64'hFFFF_0000_0000_1234, 1'b1, 1'b0, 4'b0000));
    add_row(enc_wide(1'b0, OPC_MOVZ, 2'd2, 16'hFFFF, 5'd3, FAM_DPI), 1'b1,
            mk_res(5'd3, 64'h0, 1'b1, 1'b0, 4'b0000));
    add_row(enc_wide(1'b0, OPC_MOVN, 2'd3, 16'hFFFF, 5'd4, FAM_DPI), 1'b1,
            mk_res(5'd4, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0, 4'b0000));
    add_row(enc_wide(1'b0, OPC_MOVK, 2'd2, 16'hABCD, 5'd0, FAM_DPI), 1'b1,
            mk_res(5'd0, 64'h0000_0000_0000_1234, 1'b1, 1'b0, 4'b0000));
    // carry out to zero, x31 as ordinary source, 32-bit wrap
    add_row(enc_arith(1'b1, OPC_ADDS, 1'b0, 12'h001, 5'd1, 5'd5, FAM_DPI), 1'b1,
            mk_res(5'd5, 64'h0, 1'b1, 1'b1, 4'b0110));
    add_row(enc_arith(1'b1, OPC_SUBS, 1'b0, 12'h000, 5'd31, 5'd6, FAM_DPI), 1'b1,
            mk_res(5'd6, 64'h0, 1'b1, 1'b1, 4'b0110));
    add_row(enc_arith(1'b0, OPC_ADDS, 1'b0, 12'h001, 5'd2, 5'd7, FAM_DPI), 1'b1,
            mk_res(5'd7, 64'h0, 1'b1, 1'b1, 4'b0110));
    // signed overflow at both widths, then a borrow
    add_row(enc_wide(1'b1, OPC_MOVN, 2'd3, 16'h8000, 5'd10, FAM_DPI), 1'b1,
            mk_res(5'd10, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 4'b0110));
    add_row(enc_arith(1'b1, OPC_ADDS, 1'b0, 12'h001, 5'd10, 5'd11, FAM_DPI), 1'b1,
            mk_res(5'd11, 64'h8000_0000_0000_0000, 1'b1, 1'b1, 4'b1001));
    add_row(enc_wide(1'b0, OPC_MOVN, 2'd1, 16'h8000, 5'd12, FAM_DPI), 1'b1,
            mk_res(5'd12, 64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0, 4'b1001));
    add_row(enc_arith(1'b0, OPC_ADDS, 1'b0, 12'h001, 5'd12, 5'd13, FAM_DPI), 1'b1,
            mk_res(5'd13, 64'h0000_0000_8000_0000, 1'b1, 1'b1, 4'b1001));
    add_row(enc_arith(1'b1, OPC_SUBS, 1'b0, 12'h001, 5'd31, 5'd14, FAM_DPI), 1'b1,
            mk_res(5'd14, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 4'b1000));
    // shifted immediates, non-flag ops, x31 as destination
    add_row(enc_arith(1'b0, OPC_SUBS, 1'b1, 12'hFFF, 5'd14, 5'd15, FAM_DPI), 1'b0, '0);
    add_row(enc_arith(1'b1, OPC_ADDS, 1'b1, 12'hFFF, 5'd1, 5'd16, FAM_DPI), 1'b0, '0);
    add_row(enc_arith(1'b1, OPC_SUB, 1'b0, 12'h001, 5'd31, 5'd17, FAM_DPI), 1'b0, '0);
    add_row(enc_arith(1'b0, OPC_ADD, 1'b0, 12'hFFF, 5'd1, 5'd31, FAM_DPI), 1'b0, '0);
    // unsupported encodings write nothing and leave flags as held
    add_row({1'b1, 2'b11, 3'b111, OPI_PCREL, 23'h7F_FFFF}, 1'b0, '0);
    add_row(enc_wide(1'b1, OPC_BAD, 2'd3, 16'hFFFF, 5'd9, FAM_DPI), 1'b0, '0);
    add_row({1'b0, 2'b00, 3'b000, OPI_EXTRACT, 23'h00_0000}, 1'b0, '0);
    add_row({1'b1, 2'b10, FAM_DPI, OPI_LOGICAL, 23'h55_5555}, 1'b0, '0);
    // bits [28:26] do not take part in decode
    add_row(enc_arith(1'b1, OPC_ADD, 1'b0, 12'h001, 5'd31, 5'd31, 3'b000), 1'b0, '0);
    add_row(enc_wide(1'b1, OPC_MOVK, 2'd1, 16'hBEEF, 5'd31, 3'b111), 1'b0, '0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      drive_beat(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want, snd_gap());
    for (int i = 0; i < N_RANDOM; i++)
      drive_beat(rand_word(), 1'b0, '0, snd_gap());
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
